// File: hw/rtl/vmpn_pkg.sv
// Shared types and constants for the vector magnitude peak normaliser.
`timescale 1ns / 1ps

package vmpn_pkg;

    // Field widths fixed by the interface
    localparam int COMP_W   = 24;   // displacement component
    localparam int LEN_W    = 24;   // vector length, unsigned Q24.0
    localparam int GAIN_W   = 16;   // output scale, Q4.12
    localparam int SUMSQ_W  = 48;   // sum of three squares
    localparam int PROD_W   = 40;   // length times gain magnitude
    localparam int QUOT_W   = 17;   // weight magnitude, up to 2^15
    localparam int STEP_W   = 5;

    // Iteration counts of the square-root and divide steps
    localparam int ROOT_STEPS = SUMSQ_W / 2;
    localparam int DIV_STEPS  = QUOT_W;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    // One input request
    typedef struct packed {
        logic signed [COMP_W-1:0] dx;
        logic signed [COMP_W-1:0] dy;
        logic signed [COMP_W-1:0] dz;
        logic                     final_vector;
    } in_item_t;

    // One result request
    typedef struct packed {
        logic signed [GAIN_W-1:0] weight;
        logic                     end_of_run;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic square;
        logic root_init;
        logic root_step;
        logic store;
        logic rd;
        logic mul;
        logic div_init;
        logic div_step;
        logic push;
        logic idx_inc;
        logic clear_set;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic final_flag;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/vmpn_ctrl.sv
// Sequencing controller for the vector magnitude peak normaliser.
`timescale 1ns / 1ps

module vmpn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vmpn_pkg::dp_stat_t stat,
    output vmpn_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_WRITE,
        ST_RD,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [vmpn_pkg::STEP_W-1:0]   step_reg;
    logic [vmpn_pkg::STEP_W-1:0]   step_next;

    localparam logic [vmpn_pkg::STEP_W-1:0] ROOT_LAST =
        vmpn_pkg::STEP_W'(vmpn_pkg::ROOT_STEPS - 1);
    localparam logic [vmpn_pkg::STEP_W-1:0] DIV_LAST =
        vmpn_pkg::STEP_W'(vmpn_pkg::DIV_STEPS - 1);

    assign in_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!stat.full) begin
                    state_next = ST_SQUARE;
                end else if (stat.final_flag) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.root_init = 1'b1;
                step_next     = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == ROOT_LAST) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.store  = 1'b1;
                state_next = stat.final_flag ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    if (stat.idx_last) begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hw/rtl/vmpn_dp.sv
// Datapath: squares, square root, length store, peak, scale and divide.
`timescale 1ns / 1ps

module vmpn_dp #(
    parameter int MAX_VECTORS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  vmpn_pkg::in_item_t                     in_item,
    input  logic                                   cfg_we,
    input  logic signed [vmpn_pkg::GAIN_W-1:0]     cfg_gain,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output vmpn_pkg::out_item_t                    out_item,
    input  vmpn_pkg::dp_cmd_t                      cmd,
    output vmpn_pkg::dp_stat_t                     stat
);

    localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1);
    localparam int LW = vmpn_pkg::LEN_W;
    localparam int SW = vmpn_pkg::SUMSQ_W;
    localparam int PW = vmpn_pkg::PROD_W;
    localparam int QW = vmpn_pkg::QUOT_W;
    localparam int GW = vmpn_pkg::GAIN_W;
    localparam int CMW = vmpn_pkg::COMP_W;
    localparam int RW = LW + 2;         // root remainder

    // Input capture and set control
    vmpn_pkg::in_item_t     item_reg;
    logic signed [GW-1:0]   gain_reg;
    logic [CW-1:0]          count_reg;
    logic [AW-1:0]          idx_reg;
    logic [LW-1:0]          peak_reg;

    // Squares and root
    logic [SW-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [SW-1:0]          rad_reg;
    logic [RW-1:0]          rem_reg;
    logic [LW-1:0]          root_reg;

    // Store and emission
    logic [LW-1:0]          store_mem [MAX_VECTORS];
    logic [LW-1:0]          rdata_reg;
    logic [PW-1:0]          prod_reg;
    logic [LW-1:0]          drem_reg;
    logic [QW-1:0]          dlo_reg;
    logic [QW-1:0]          quot_reg;

    // Output register
    logic                   out_valid_reg;
    vmpn_pkg::out_item_t    out_reg;

    // Combinational helpers
    logic [CMW-1:0]         ax, ay, az;
    logic [GW-1:0]          gain_mag;
    logic [RW+1:0]          rt_shift;
    logic [RW+1:0]          rt_trial;
    logic [LW:0]            dv_shift;
    logic                   force_zero;
    logic [QW-1:0]          quot_signed;

    // Take magnitudes of the components and the gain
    assign ax = item_reg.dx[CMW-1] ? CMW'(-item_reg.dx) : CMW'(item_reg.dx);
    assign ay = item_reg.dy[CMW-1] ? CMW'(-item_reg.dy) : CMW'(item_reg.dy);
    assign az = item_reg.dz[CMW-1] ? CMW'(-item_reg.dz) : CMW'(item_reg.dz);
    assign gain_mag = gain_reg[GW-1] ? GW'(-gain_reg) : GW'(gain_reg);

    // One bit of the floor square root per step
    assign rt_shift = {rem_reg, rad_reg[SW-1 -: 2]};
    assign rt_trial = {2'b00, root_reg, 2'b01};

    // One quotient bit per step
    assign dv_shift = {drem_reg, dlo_reg[QW-1]};

    assign force_zero = (gain_reg == '0) || (peak_reg == '0);
    assign quot_signed = gain_reg[GW-1] ? QW'(-quot_reg) : quot_reg;

    assign stat.full       = (count_reg == CW'(MAX_VECTORS));
    assign stat.final_flag = item_reg.final_vector;
    assign stat.idx_last   = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Control state: gain, count, index, peak, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= vmpn_pkg::GAIN_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_gain;
            end
            if (cmd.clear_set) begin
                count_reg <= '0;
                idx_reg   <= '0;
                peak_reg  <= '0;
            end else begin
                if (cmd.store) begin
                    count_reg <= count_reg + 1'b1;
                    if (root_reg > peak_reg) begin
                        peak_reg <= root_reg;
                    end
                end
                if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture, squares, root iteration
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= in_item;
        end
        if (cmd.square) begin
            sqx_reg <= SW'(ax * ax);
            sqy_reg <= SW'(ay * ay);
            sqz_reg <= SW'(az * az);
        end
        if (cmd.root_init) begin
            rad_reg  <= sqx_reg + sqy_reg + sqz_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= {rad_reg[SW-3:0], 2'b00};
            if (rt_shift >= rt_trial) begin
                rem_reg  <= RW'(rt_shift - rt_trial);
                root_reg <= {root_reg[LW-2:0], 1'b1};
            end else begin
                rem_reg  <= RW'(rt_shift);
                root_reg <= {root_reg[LW-2:0], 1'b0};
            end
        end
    end

    // Length store: write at the fill position, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            store_mem[count_reg[AW-1:0]] <= root_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= store_mem[idx_reg];
        end
    end

    // Scale, divide by the peak, load the output register
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PW'(rdata_reg * gain_mag);
        end
        if (cmd.div_init) begin
            drem_reg <= LW'(prod_reg[PW-1:QW]);
            dlo_reg  <= prod_reg[QW-1:0];
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            dlo_reg <= {dlo_reg[QW-2:0], 1'b0};
            if (dv_shift >= {1'b0, peak_reg}) begin
                drem_reg <= LW'(dv_shift - {1'b0, peak_reg});
                quot_reg <= {quot_reg[QW-2:0], 1'b1};
            end else begin
                drem_reg <= LW'(dv_shift);
                quot_reg <= {quot_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.push) begin
            out_reg.weight     <= force_zero ? '0 : GW'(quot_signed);
            out_reg.end_of_run <= stat.idx_last;
        end
    end

endmodule

// File: hw/rtl/vector_magnitude_peak_normalizer.sv
// Top level of the vector magnitude peak normaliser.
// Loads a set of 3-D displacement vectors, one request each, storing the floor
// Euclidean length of each and tracking the peak length. The request marked
// final_vector triggers one result per stored vector in load order, with
// weight = length * gain / peak truncated toward zero (Q4.12), zero when gain
// or peak is zero. Vectors beyond MAX_VECTORS are dropped. The square root is
// taken a bit per cycle and the divide a quotient bit per cycle; a vector is
// processed fully before the next input is taken, and each result waits while
// the result side stalls.
// Inputs are not taken while a set is being emitted. gain is written through
// the cfg channel, which is always ready; write it only while idle.
`timescale 1ns / 1ps

module vector_magnitude_peak_normalizer #(
    parameter int MAX_VECTORS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  vmpn_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output vmpn_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic signed [vmpn_pkg::GAIN_W-1:0]    cfg_wdata
);

    vmpn_pkg::dp_cmd_t  cmd;
    vmpn_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequence each request through the datapath
    vmpn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic, store and output register
    vmpn_dp #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (s_data),
        .cfg_we    (cfg_valid),
        .cfg_gain  (cfg_wdata),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_item  (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the vector magnitude peak normaliser.
`timescale 1ns / 1ps

module tb_top;

    localparam int     STORE_CAP     = 64;
    localparam int     RANDOM_ITEMS  = 320;
    // Leave room for one vector still in flight in the block
    localparam int     SETTLE_CYCLES = 60;
    // Worst case is far beyond any real run: every request followed by a full set
    // of results, each waiting out the longest receiver stall
    localparam longint CYCLE_LIMIT   = 20_000_000;

    localparam int COMP_MAX = 8388607;
    localparam int COMP_MIN = -8388608;

    localparam int CW = vmpn_pkg::COMP_W;
    localparam int GW = vmpn_pkg::GAIN_W;
    localparam int LW = vmpn_pkg::LEN_W;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    vmpn_pkg::in_item_t       s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    vmpn_pkg::out_item_t      m_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic signed [GW-1:0]     cfg_wdata = '0;

    // Hand-worked expectation that travels with the current request
    logic                s_typed      = 1'b0;
    vmpn_pkg::out_item_t s_typed_item = '0;

    vector_magnitude_peak_normalizer #(
        .MAX_VECTORS(STORE_CAP)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    longint cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("[vector_magnitude_peak_normalizer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor state: stored lengths, running peak, count and gain
    // ------------------------------------------------------------------
    logic [LW-1:0]            len_store [STORE_CAP];
    logic [LW-1:0]            peak_len   = '0;
    int unsigned              held_count = 0;
    logic signed [GW-1:0]     gain_now   = vmpn_pkg::GAIN_RESET;
    vmpn_pkg::out_item_t      weights_due [$];
    int unsigned              errors     = 0;

    // Floor square root, one result bit at a time from the top
    function automatic logic [LW-1:0] floor_root(input longint unsigned sumsq);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = LW - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sumsq) root = trial;
        end
        return root[LW-1:0];
    endfunction

    function automatic longint unsigned square_of(input logic signed [CW-1:0] c);
        longint v;
        v = longint'(c);
        return longint'(v * v);
    endfunction

    // Append one expected result behind the ones already due
    task automatic queue_weight(input vmpn_pkg::out_item_t res);
        weights_due.insert(weights_due.size(), res);
    endtask

    // Store one vector's length and, on the final mark, queue the set's weights
    task automatic absorb_vector(input vmpn_pkg::in_item_t item, input logic typed,
                                 input vmpn_pkg::out_item_t typed_item);
        logic [LW-1:0]       len;
        longint              w;
        vmpn_pkg::out_item_t res;
        if (held_count < STORE_CAP) begin
            len = floor_root(square_of(item.dx) + square_of(item.dy)
                             + square_of(item.dz));
            len_store[held_count] = len;
            held_count++;
            if (len > peak_len) peak_len = len;
        end
        if (item.final_vector) begin
            if (typed) begin
                queue_weight(typed_item);
            end else begin
                for (int unsigned k = 0; k < held_count; k++) begin
                    w = 0;
                    if (gain_now != 0 && peak_len != 0)
                        w = (longint'(len_store[k]) * longint'(gain_now))
                            / longint'(peak_len);
                    res.weight     = w[GW-1:0];
                    res.end_of_run = (k + 1 == held_count);
                    queue_weight(res);
                end
            end
            held_count = 0;
            peak_len   = '0;
        end
    endtask

    // Track handshakes and compare each result with the oldest expectation
    always @(posedge aclk) begin : check_results
        vmpn_pkg::out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (weights_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got weight %0d end %0b",
                             $time, m_data.weight, m_data.end_of_run);
                end else begin
                    want = weights_due.pop_front();
                    if (m_data.weight !== want.weight) begin
                        errors++;
                        $display("%0t: weight expected %0d got %0d",
                                 $time, want.weight, m_data.weight);
                    end
                    if (m_data.end_of_run !== want.end_of_run) begin
                        errors++;
                        $display("%0t: end_of_run expected %0b got %0b",
                                 $time, want.end_of_run, m_data.end_of_run);
                    end
                end
            end
            if (cfg_valid && cfg_ready) gain_now = cfg_wdata;
            if (s_valid && s_ready) absorb_vector(s_data, s_typed, s_typed_item);
        end
    end

    // ------------------------------------------------------------------
    // Idle gaps: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: stretches with stalls and without, chosen at random
    int unsigned rx_hold      = 0;
    int unsigned rx_mode_left = 0;
    logic        rx_stalls    = 1'b0;
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_stalls    = ($urandom_range(0, 2) != 0);
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 2) == 0) rx_hold = idle_gap();
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    logic tx_stalls = 1'b0;

    // Present one request at a falling edge and hold it until accepted
    task automatic send_vector(input vmpn_pkg::in_item_t item, input logic typed,
                               input vmpn_pkg::out_item_t typed_item);
        int unsigned gap;
        gap = (tx_stalls && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data       <= item;
        s_typed      <= typed;
        s_typed_item <= typed_item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (weights_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gain(input logic signed [GW-1:0] g);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_wdata <= g;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] pick_component();
        logic [31:0] r;
        int          v;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                r = $urandom;
                return r[CW-1:0];
            end
            3: begin
                v = $urandom_range(0, 400);
                return CW'(v - 200);
            end
            4: begin
                case ($urandom_range(0, 2))
                    0:       return CW'(COMP_MAX);
                    1:       return CW'(COMP_MIN);
                    default: return '0;
                endcase
            end
            default: return CW'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic vmpn_pkg::in_item_t random_vector();
        vmpn_pkg::in_item_t item;
        item.dx           = pick_component();
        item.dy           = pick_component();
        item.dz           = pick_component();
        item.final_vector = 1'b0;
        return item;
    endfunction

    function automatic logic signed [GW-1:0] pick_gain();
        logic [31:0] r;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GW'(-32768);
            2:       return GW'(32767);
            3:       return vmpn_pkg::GAIN_RESET;
            default: begin
                r = $urandom;
                return r[GW-1:0];
            end
        endcase
    endfunction

    // Mostly short sets, a few that fill or overrun the store
    function automatic int unsigned pick_set_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 40);
        return $urandom_range(60, 72);
    endfunction

    // ------------------------------------------------------------------
    // Directed requests; typed weights only for single-vector sets
    // ------------------------------------------------------------------
    typedef struct {
        bit load_gain;
        int gain;
        int dx;
        int dy;
        int dz;
        bit fin;
        bit typed;
        int weight;
    } row_t;

    row_t directed_rows [21] = '{
        // zero peak: a lone zero vector
        '{1'b0,      0,        0,        0,        0, 1'b1, 1'b1,      0},
        // 3-4-5 vector alone scales to the unit gain
        '{1'b0,      0,        3,        4,        0, 1'b1, 1'b1,   4096},
        // extreme components
        '{1'b0,      0, COMP_MAX,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0, COMP_MIN,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0,        0, COMP_MIN, COMP_MAX, 1'b0, 1'b0,      0},
        '{1'b0,      0, COMP_MIN, COMP_MIN, COMP_MIN, 1'b1, 1'b0,      0},
        // zero gain
        '{1'b1,      0,      100,      200,      300, 1'b1, 1'b1,      0},
        // most negative gain
        '{1'b1, -32768,        1,        0,        0, 1'b1, 1'b1, -32768},
        '{1'b0,      0,        5,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0,      -10,        0,        0, 1'b1, 1'b0,      0},
        // most positive gain
        '{1'b1,  32767,        0,        0,       -7, 1'b1, 1'b1,  32767},
        '{1'b0,      0,        1,        1,        1, 1'b0, 1'b0,      0},
        '{1'b0,      0,        0,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0,     4095,    -4096,       12, 1'b1, 1'b0,      0},
        // a long vector next to tiny ones
        '{1'b1,   4096, COMP_MAX, COMP_MAX, COMP_MAX, 1'b0, 1'b0,      0},
        '{1'b0,      0,       -1,       -1,       -1, 1'b0, 1'b0,      0},
        '{1'b0,      0,        0,        0,        1, 1'b1, 1'b0,      0},
        // zero peak over several vectors
        '{1'b0,      0,        0,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0,        0,        0,        0, 1'b1, 1'b0,      0},
        // negative gain, quotient truncated toward zero
        '{1'b1,     -1,        7,        0,        0, 1'b0, 1'b0,      0},
        '{1'b0,      0,        2,        0,        0, 1'b1, 1'b0,      0}
    };

    initial begin : stimulus
        row_t                r;
        vmpn_pkg::in_item_t  item;
        vmpn_pkg::out_item_t typed_item;
        int unsigned         sent;
        int unsigned         set_len;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests, back to back
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.load_gain) write_gain(GW'(r.gain));
            item.dx                = CW'(r.dx);
            item.dy                = CW'(r.dy);
            item.dz                = CW'(r.dz);
            item.final_vector      = r.fin;
            typed_item.weight      = GW'(r.weight);
            typed_item.end_of_run  = 1'b1;
            send_vector(item, r.typed, typed_item);
        end
        typed_item = '0;

        // Overrun the store with long vectors that must be dropped,
        // the final mark falling on a dropped one
        write_gain(pick_gain());
        tx_stalls = 1'b1;
        for (int k = 0; k < STORE_CAP + 6; k++) begin
            item = random_vector();
            if (k >= STORE_CAP) begin
                item.dx = CW'(COMP_MIN);
                item.dy = CW'(COMP_MIN);
                item.dz = CW'(COMP_MIN);
            end
            item.final_vector = (k == STORE_CAP + 5);
            send_vector(item, 1'b0, typed_item);
        end
        // Fill the store exactly
        for (int k = 0; k < STORE_CAP; k++) begin
            item              = random_vector();
            item.final_vector = (k == STORE_CAP - 1);
            send_vector(item, 1'b0, typed_item);
        end

        // Random sets in phases, a new gain for each phase
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_gain(pick_gain());
            tx_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) begin
                if (sent < RANDOM_ITEMS) begin
                    set_len = pick_set_length();
                    for (int unsigned k = 0; k < set_len; k++) begin
                        item              = random_vector();
                        item.final_vector = (k + 1 == set_len);
                        send_vector(item, 1'b0, typed_item);
                        sent++;
                        // hold off now and then until the block has caught up
                        if ($urandom_range(0, 149) == 0) wait_idle();
                    end
                end
            end
        end

        wait_idle();
        if (errors == 0 && weights_due.size() == 0) begin
            $display("[vector_magnitude_peak_normalizer] OK");
        end else begin
            $display("[vector_magnitude_peak_normalizer] ERROR");
        end
        $finish;
    end

endmodule
